### design/lidar_circle_zone_guard_unit_assert.svh
// Assertion shorthands for the guard unit, clocked on clk, idle in reset.
`ifndef LIDAR_CIRCLE_ZONE_GUARD_UNIT_ASSERT_SVH
`define LIDAR_CIRCLE_ZONE_GUARD_UNIT_ASSERT_SVH

// Same-cycle implication.
`define LCZG_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lczg assertion failed");

// Next-cycle implication.
`define LCZG_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lczg assertion failed");

`endif

### design/lczg_pkg.sv
package lczg_pkg;

    localparam int ANGLE_STEPS_DEF    = 360;
    localparam int TRIG_FRAC_BITS_DEF = 15;

    localparam int ANGLE_W     = 9;
    localparam int DIST_W      = 14;
    localparam int XMAG_W      = DIST_W + 1;
    localparam int OFFSET_W    = 12;
    localparam int RADIUS_W    = 12;
    localparam int RADIUS_SQ_W = 2 * RADIUS_W;
    localparam int HOLD_W      = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int ANGLE_COUNT = 1 << ANGLE_W;

    localparam logic                DETECT_ENABLE_RST = 1'b1;
    localparam logic [OFFSET_W-1:0] CENTER_OFFSET_RST = 12'd105;
    localparam logic [RADIUS_W-1:0] RADIUS_RST        = 12'd180;
    localparam logic [HOLD_W-1:0]   HOLD_TICKS_RST    = 16'd8400;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] Q30_ONE     = 64'd1 << 30;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_DETECT_ENABLE = 2'd0,
        CFG_CENTER_OFFSET = 2'd1,
        CFG_RADIUS        = 2'd2,
        CFG_HOLD_TICKS    = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_PAUSE  = 2'd1,
        EV_RESUME = 2'd2
    } event_t;

    typedef struct packed {
        logic                    detect_enable;
        logic [OFFSET_W-1:0]     center_offset_mm;
        logic [RADIUS_SQ_W-1:0]  radius_sq;
        logic [HOLD_W-1:0]       hold_ticks;
    } cfg_t;

    typedef enum logic [1:0] {
        MUL_DIST_COS = 2'd0,
        MUL_DIST_SIN = 2'd1,
        MUL_X_SQ     = 2'd2,
        MUL_Y_SQ     = 2'd3
    } mul_sel_t;

    typedef struct packed {
        logic     load;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     x_en;
        logic     y_en;
        logic     acc_en;
        logic     finish;
    } dp_cmd_t;

    typedef struct packed {
        logic live_in;
        logic out_free;
    } dp_status_t;

    typedef enum logic [2:0] {
        ST_IDLE    = 3'd0,
        ST_MUL_COS = 3'd1,
        ST_MUL_SIN = 3'd2,
        ST_SQ_X    = 3'd3,
        ST_SQ_Y    = 3'd4,
        ST_FINISH  = 3'd5
    } ctrl_state_t;

    function automatic logic [63:0] mul30(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] p;
        p = a * b;
        return p >> 30;
    endfunction

    function automatic logic [63:0] one_minus(input logic [63:0] v);
        return (v > Q30_ONE) ? 64'd0 : Q30_ONE - v;
    endfunction

    function automatic logic [63:0] to_frac(input logic [63:0] v, input int frac_bits);
        logic [63:0] r;
        logic [63:0] cap;
        r   = (v + (64'd1 << (29 - frac_bits))) >> (30 - frac_bits);
        cap = (64'd1 << frac_bits) - 64'd1;
        return (r > cap) ? cap : r;
    endfunction

    // Sine in the upper word, cosine in the lower word, both as fractions.
    function automatic logic [63:0] trig_frac(input logic [63:0] x, input int frac_bits);
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] c;
        x2 = mul30(x, x);
        t  = one_minus(x2 / 64'd156);
        t  = one_minus(mul30(x2, t) / 64'd110);
        t  = one_minus(mul30(x2, t) / 64'd72);
        t  = one_minus(mul30(x2, t) / 64'd42);
        t  = one_minus(mul30(x2, t) / 64'd20);
        t  = one_minus(mul30(x2, t) / 64'd6);
        s  = to_frac(mul30(x, t), frac_bits);
        t  = one_minus(x2 / 64'd182);
        t  = one_minus(mul30(x2, t) / 64'd132);
        t  = one_minus(mul30(x2, t) / 64'd90);
        t  = one_minus(mul30(x2, t) / 64'd56);
        t  = one_minus(mul30(x2, t) / 64'd30);
        t  = one_minus(mul30(x2, t) / 64'd12);
        t  = one_minus(mul30(x2, t) / 64'd2);
        c  = to_frac(t, frac_bits);
        return {s[31:0], c[31:0]};
    endfunction

endpackage

### design/lidar_circle_zone_guard_unit.sv
// Lidar guard-zone supervisor. Each input word is a lidar sample or a time tick and
// produces exactly one output word (hit, pause state after the word, event). A sample
// that is enabled and unflagged is placed in x/y via a sine/cosine table and tested
// against the guard circle; a hit pauses the unit, and while paused, ticks count until
// hold_ticks hit-free ticks have passed and the unit resumes. A sample that is tested
// presents its output word after a table lookup at acceptance, four passes through the
// one shared multiplier for d*cos, d*sin, x*x and y*y, then compare and update; the
// next word is taken only once that update is done. Ticks and ignored samples go
// from acceptance straight to the update step, which presents their word.
// One word is in flight at a time; the output register lets a new word enter while the
// previous result waits, and the final update step holds until that register is free.
// Configuration writes are taken every cycle and should be made while the unit is idle.
`include "lidar_circle_zone_guard_unit_assert.svh"

module lidar_circle_zone_guard_unit #(
    parameter int ANGLE_STEPS    = lczg_pkg::ANGLE_STEPS_DEF,
    parameter int TRIG_FRAC_BITS = lczg_pkg::TRIG_FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lczg_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [lczg_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              op,
    input  logic [lczg_pkg::ANGLE_W-1:0]      angle_deg,
    input  logic [lczg_pkg::DIST_W-1:0]       range_mm,
    input  logic                              sample_error,
    input  logic                              weak_signal,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              hit,
    output logic                              paused_now,
    output logic [1:0]                        event_res
);

    lczg_pkg::cfg_t       cfg;
    lczg_pkg::dp_cmd_t    cmd;
    lczg_pkg::dp_status_t status;

    lczg_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lczg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    lczg_datapath #(
        .ANGLE_STEPS    (ANGLE_STEPS),
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg          (cfg),
        .op           (op),
        .angle_deg    (angle_deg),
        .range_mm     (range_mm),
        .sample_error (sample_error),
        .weak_signal  (weak_signal),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .hit          (hit),
        .paused_now   (paused_now),
        .event_res    (event_res)
    );

    `LCZG_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready)
    `LCZG_ASSERT_IMP(a_pause_on_hit, out_valid && (event_res == lczg_pkg::EV_PAUSE), hit && paused_now)
    `LCZG_ASSERT_IMP(a_resume_clear, out_valid && (event_res == lczg_pkg::EV_RESUME), !hit && !paused_now)
    `LCZG_ASSERT_IMP(a_hit_pauses, out_valid && hit, paused_now)

endmodule

### design/lczg_cfg.sv
module lczg_cfg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [lczg_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [lczg_pkg::CFG_DATA_W-1:0]    cfg_data,
    output lczg_pkg::cfg_t                     cfg
);

    logic                                  detect_enable_reg;
    logic                                  detect_enable_next;
    logic [lczg_pkg::OFFSET_W-1:0]         center_offset_reg;
    logic [lczg_pkg::OFFSET_W-1:0]         center_offset_next;
    logic [lczg_pkg::RADIUS_SQ_W-1:0]      radius_sq_reg;
    logic [lczg_pkg::RADIUS_SQ_W-1:0]      radius_sq_next;
    logic [lczg_pkg::HOLD_W-1:0]           hold_ticks_reg;
    logic [lczg_pkg::HOLD_W-1:0]           hold_ticks_next;
    logic [lczg_pkg::RADIUS_W-1:0]         radius_w;

    assign cfg_ready = 1'b1;
    assign radius_w  = cfg_data[lczg_pkg::RADIUS_W-1:0];

    always_comb
    begin
        detect_enable_next = detect_enable_reg;
        center_offset_next = center_offset_reg;
        radius_sq_next     = radius_sq_reg;
        hold_ticks_next    = hold_ticks_reg;
        if (cfg_valid)
        begin
            case (lczg_pkg::cfg_index_t'(cfg_index))
                lczg_pkg::CFG_DETECT_ENABLE: detect_enable_next = cfg_data[0];
                lczg_pkg::CFG_CENTER_OFFSET:
                    center_offset_next = cfg_data[lczg_pkg::OFFSET_W-1:0];
                lczg_pkg::CFG_RADIUS:
                    radius_sq_next = lczg_pkg::RADIUS_SQ_W'(radius_w) *
                                     lczg_pkg::RADIUS_SQ_W'(radius_w);
                lczg_pkg::CFG_HOLD_TICKS:
                    hold_ticks_next = cfg_data[lczg_pkg::HOLD_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            detect_enable_reg <= lczg_pkg::DETECT_ENABLE_RST;
            center_offset_reg <= lczg_pkg::CENTER_OFFSET_RST;
            radius_sq_reg     <= lczg_pkg::RADIUS_SQ_W'(lczg_pkg::RADIUS_RST) *
                                 lczg_pkg::RADIUS_SQ_W'(lczg_pkg::RADIUS_RST);
            hold_ticks_reg    <= lczg_pkg::HOLD_TICKS_RST;
        end
        else
        begin
            detect_enable_reg <= detect_enable_next;
            center_offset_reg <= center_offset_next;
            radius_sq_reg     <= radius_sq_next;
            hold_ticks_reg    <= hold_ticks_next;
        end
    end

    assign cfg.detect_enable    = detect_enable_reg;
    assign cfg.center_offset_mm = center_offset_reg;
    assign cfg.radius_sq        = radius_sq_reg;
    assign cfg.hold_ticks       = hold_ticks_reg;

endmodule

### design/lczg_ctrl.sv
module lczg_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  lczg_pkg::dp_status_t status,
    output lczg_pkg::dp_cmd_t    cmd
);

    lczg_pkg::ctrl_state_t state_reg;
    lczg_pkg::ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lczg_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        in_ready    = 1'b0;
        cmd         = '0;
        cmd.mul_sel = lczg_pkg::MUL_DIST_COS;
        case (state_reg)
            lczg_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = status.live_in ? lczg_pkg::ST_MUL_COS : lczg_pkg::ST_FINISH;
                end
            end
            lczg_pkg::ST_MUL_COS:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = lczg_pkg::MUL_DIST_COS;
                state_next  = lczg_pkg::ST_MUL_SIN;
            end
            lczg_pkg::ST_MUL_SIN:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = lczg_pkg::MUL_DIST_SIN;
                cmd.x_en    = 1'b1;
                state_next  = lczg_pkg::ST_SQ_X;
            end
            lczg_pkg::ST_SQ_X:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = lczg_pkg::MUL_X_SQ;
                cmd.y_en    = 1'b1;
                state_next  = lczg_pkg::ST_SQ_Y;
            end
            lczg_pkg::ST_SQ_Y:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = lczg_pkg::MUL_Y_SQ;
                cmd.acc_en  = 1'b1;
                state_next  = lczg_pkg::ST_FINISH;
            end
            lczg_pkg::ST_FINISH:
            begin
                // hold until the output word slot is free
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = lczg_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lczg_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### design/lczg_datapath.sv
module lczg_datapath #(
    parameter int ANGLE_STEPS    = lczg_pkg::ANGLE_STEPS_DEF,
    parameter int TRIG_FRAC_BITS = lczg_pkg::TRIG_FRAC_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  lczg_pkg::dp_cmd_t                cmd,
    output lczg_pkg::dp_status_t             status,
    input  lczg_pkg::cfg_t                   cfg,
    input  logic                             op,
    input  logic [lczg_pkg::ANGLE_W-1:0]     angle_deg,
    input  logic [lczg_pkg::DIST_W-1:0]      range_mm,
    input  logic                             sample_error,
    input  logic                             weak_signal,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             hit,
    output logic                             paused_now,
    output logic [1:0]                       event_res
);

    localparam int F      = TRIG_FRAC_BITS;
    localparam int DW     = lczg_pkg::DIST_W;
    localparam int MW     = lczg_pkg::XMAG_W;
    localparam int OPB_W  = (F > MW) ? F : MW;
    localparam int PROD_W = MW + OPB_W;
    localparam int ROM_W  = 2 + 2 * F;
    localparam int SQ_W   = 2 * MW;
    localparam int SUM_W  = SQ_W + 1;
    localparam int XS_W   = MW + 2;
    localparam int HW     = lczg_pkg::HOLD_W;

    logic [ROM_W-1:0] rom [lczg_pkg::ANGLE_COUNT];

    for (genvar g = 0; g < lczg_pkg::ANGLE_COUNT; g++)
    begin : g_rom
        localparam int unsigned IDX  = g % ANGLE_STEPS;
        localparam int unsigned QUAD = (IDX * 4) / ANGLE_STEPS;
        localparam int unsigned RES  = IDX * 4 - QUAD * ANGLE_STEPS;
        localparam logic [63:0] PHI  = (64'(RES) * lczg_pkg::HALF_PI_Q30) / 64'(ANGLE_STEPS);
        localparam logic [63:0] SC   = lczg_pkg::trig_frac(PHI, F);
        localparam logic [F-1:0] SV  = SC[32+F-1:32];
        localparam logic [F-1:0] CV  = SC[F-1:0];
        localparam logic CNEG = (QUAD == 1) || (QUAD == 2);
        localparam logic SNEG = (QUAD >= 2);
        localparam logic ODD  = (QUAD % 2) == 1;
        assign rom[g] = {CNEG, SNEG, ODD ? SV : CV, ODD ? CV : SV};
    end

    logic [ROM_W-1:0]       rom_reg;
    logic [ROM_W-1:0]       rom_next;
    logic [DW-1:0]          dist_reg;
    logic [DW-1:0]          dist_next;
    logic                   op_reg;
    logic                   op_next;
    logic                   live_reg;
    logic                   live_next;
    logic [PROD_W-1:0]      prod_reg;
    logic [PROD_W-1:0]      prod_next;
    logic [MW-1:0]          xmag_reg;
    logic [MW-1:0]          xmag_next;
    logic [DW-1:0]          ymag_reg;
    logic [DW-1:0]          ymag_next;
    logic [SQ_W-1:0]        acc_reg;
    logic [SQ_W-1:0]        acc_next;
    logic                   paused_reg;
    logic                   paused_next;
    logic [HW-1:0]          quiet_reg;
    logic [HW-1:0]          quiet_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic                   hit_reg;
    logic                   hit_next;
    logic                   paused_out_reg;
    logic                   paused_out_next;
    lczg_pkg::event_t       event_reg;
    lczg_pkg::event_t       event_next;

    logic                   cneg;
    logic [F-1:0]           cmag;
    logic [F-1:0]           smag;
    logic [MW-1:0]          op_a;
    logic [OPB_W-1:0]       op_b;
    logic [DW-1:0]          scaled;
    logic signed [XS_W-1:0] x_val;
    logic [XS_W-1:0]        x_abs;
    logic [SUM_W-1:0]       dist_sq;
    logic                   hit_w;
    logic [HW-1:0]          quiet_inc;
    logic                   st_paused;
    logic [HW-1:0]          st_quiet;
    lczg_pkg::event_t       st_event;

    assign cneg = rom_reg[ROM_W-1];
    assign cmag = rom_reg[2*F-1:F];
    assign smag = rom_reg[F-1:0];

    assign status.live_in  = !op && cfg.detect_enable && !sample_error && !weak_signal;
    assign status.out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        case (cmd.mul_sel)
            lczg_pkg::MUL_DIST_COS:
            begin
                op_a = MW'(dist_reg);
                op_b = OPB_W'(cmag);
            end
            lczg_pkg::MUL_DIST_SIN:
            begin
                op_a = MW'(dist_reg);
                op_b = OPB_W'(smag);
            end
            lczg_pkg::MUL_X_SQ:
            begin
                op_a = xmag_reg;
                op_b = OPB_W'(xmag_reg);
            end
            lczg_pkg::MUL_Y_SQ:
            begin
                op_a = MW'(ymag_reg);
                op_b = OPB_W'(ymag_reg);
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign scaled = prod_reg[F+DW-1:F];
    assign x_val  = (cneg ? -$signed(XS_W'(scaled)) : $signed(XS_W'(scaled)))
                    - $signed(XS_W'(cfg.center_offset_mm));
    assign x_abs  = x_val[XS_W-1] ? XS_W'(-x_val) : XS_W'(x_val);

    assign dist_sq = SUM_W'(acc_reg) + SUM_W'(prod_reg[SQ_W-1:0]);
    assign hit_w   = live_reg && (dist_sq < SUM_W'(cfg.radius_sq));

    assign quiet_inc = (quiet_reg == '1) ? quiet_reg : quiet_reg + HW'(1);

    always_comb
    begin
        st_paused = paused_reg;
        st_quiet  = quiet_reg;
        st_event  = lczg_pkg::EV_NONE;
        if (!op_reg)
        begin
            if (hit_w)
            begin
                st_event  = paused_reg ? lczg_pkg::EV_NONE : lczg_pkg::EV_PAUSE;
                st_paused = 1'b1;
                st_quiet  = '0;
            end
        end
        else if (paused_reg)
        begin
            if (quiet_inc >= cfg.hold_ticks)
            begin
                st_paused = 1'b0;
                st_quiet  = '0;
                st_event  = lczg_pkg::EV_RESUME;
            end
            else
            begin
                st_quiet = quiet_inc;
            end
        end
    end

    always_comb
    begin
        rom_next        = cmd.load ? rom[angle_deg] : rom_reg;
        dist_next       = cmd.load ? range_mm : dist_reg;
        op_next         = cmd.load ? op : op_reg;
        live_next       = cmd.load ? status.live_in : live_reg;
        prod_next       = cmd.mul_en ? PROD_W'(op_a) * PROD_W'(op_b) : prod_reg;
        xmag_next       = cmd.x_en ? x_abs[MW-1:0] : xmag_reg;
        ymag_next       = cmd.y_en ? scaled : ymag_reg;
        acc_next        = cmd.acc_en ? prod_reg[SQ_W-1:0] : acc_reg;
        paused_next     = cmd.finish ? st_paused : paused_reg;
        quiet_next      = cmd.finish ? st_quiet : quiet_reg;
        hit_next        = cmd.finish ? hit_w : hit_reg;
        paused_out_next = cmd.finish ? st_paused : paused_out_reg;
        event_next      = cmd.finish ? st_event : event_reg;
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        rom_reg        <= rom_next;
        dist_reg       <= dist_next;
        op_reg         <= op_next;
        live_reg       <= live_next;
        prod_reg       <= prod_next;
        xmag_reg       <= xmag_next;
        ymag_reg       <= ymag_next;
        acc_reg        <= acc_next;
        hit_reg        <= hit_next;
        paused_out_reg <= paused_out_next;
        event_reg      <= event_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            paused_reg    <= 1'b0;
            quiet_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            paused_reg    <= paused_next;
            quiet_reg     <= quiet_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign hit        = hit_reg;
    assign paused_now = paused_out_reg;
    assign event_res  = event_reg;

endmodule
